/* rtl/irgf_pkg.sv */
// ----------------------------------------------------------------------------
// irgf_pkg
// Shared types and codes of the interval registry gap finder.
// ----------------------------------------------------------------------------
package irgf_pkg;

    localparam logic [1:0] REQ_CHECK = 2'd0;
    localparam logic [1:0] REQ_OVL   = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    localparam logic [1:0] KIND_GAP  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_OVL  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_ARG   = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_SCAN,
        OP_TAIL,
        OP_OVL,
        OP_FLUSH,
        OP_MERGE_SETUP,
        OP_INS_SETUP,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_WR_NEW,
        OP_GAP_RD,
        OP_OUT_GAP,
        OP_OUT_DONE,
        OP_OUT_ERR_ARG,
        OP_OUT_ERR_FULL,
        OP_OUT_OVL
    } dp_op_t;

    // datapath status
    typedef struct packed {
        logic [1:0] req_type;
        logic       bad;
        logic       ovl_empty;
        logic       want;
        logic       cov;
        logic       stop;
        logic       more;
        logic       first_found;
        logic       full;
        logic       merge_more;
        logic       ins_more;
        logic       gaps_zero;
        logic       gap_last;
        logic       out_free;
    } dp_status_t;

endpackage

/* rtl/irgf_ctrl.sv */
// ----------------------------------------------------------------------------
// irgf_ctrl
// Request sequencer: scan, merge/insert shift, gap emission, responses.
// ----------------------------------------------------------------------------
module irgf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  irgf_pkg::dp_status_t st,
    output irgf_pkg::dp_op_t     op
);
    import irgf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_C_RD,
        S_C_SCAN,
        S_DECIDE,
        S_M_LOOP,
        S_M_WR,
        S_I_LOOP,
        S_I_WR,
        S_FIN,
        S_G_RD,
        S_G_OUT,
        S_O_RD,
        S_O_SCAN,
        S_RESP
    } state_t;

    state_t   state_reg, state_next;
    dp_op_t   resp_reg, resp_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESP;
                resp_next  = OP_OUT_DONE;
                case (st.req_type)
                    REQ_CHECK:
                    begin
                        if (st.bad)
                            resp_next = OP_OUT_ERR_ARG;
                        else
                            state_next = S_C_RD;
                    end
                    REQ_OVL:
                    begin
                        resp_next = OP_OUT_OVL;
                        if (!st.ovl_empty)
                            state_next = S_O_RD;
                    end
                    REQ_FLUSH: op = OP_FLUSH;
                    default: ;
                endcase
            end
            S_C_RD:
            begin
                if (st.cov)
                begin
                    resp_next  = OP_OUT_DONE;
                    state_next = S_RESP;
                end
                else if (!st.stop && st.more)
                begin
                    op         = OP_READ;
                    state_next = S_C_SCAN;
                end
                else
                begin
                    op         = OP_TAIL;
                    state_next = S_DECIDE;
                end
            end
            S_C_SCAN:
            begin
                op         = OP_SCAN;
                state_next = S_C_RD;
            end
            S_DECIDE:
            begin
                if (st.first_found)
                begin
                    op         = OP_MERGE_SETUP;
                    state_next = S_M_LOOP;
                end
                else if (st.full)
                begin
                    resp_next  = OP_OUT_ERR_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    op         = OP_INS_SETUP;
                    state_next = S_I_LOOP;
                end
            end
            S_M_LOOP:
            begin
                if (st.merge_more)
                begin
                    op         = OP_SHIFT_RD;
                    state_next = S_M_WR;
                end
                else
                begin
                    op         = OP_WR_NEW;
                    state_next = S_FIN;
                end
            end
            S_M_WR:
            begin
                op         = OP_SHIFT_WR;
                state_next = S_M_LOOP;
            end
            S_I_LOOP:
            begin
                if (st.ins_more)
                begin
                    op         = OP_SHIFT_RD;
                    state_next = S_I_WR;
                end
                else
                begin
                    op         = OP_WR_NEW;
                    state_next = S_FIN;
                end
            end
            S_I_WR:
            begin
                op         = OP_SHIFT_WR;
                state_next = S_I_LOOP;
            end
            S_FIN:
            begin
                if (!st.want || st.gaps_zero)
                begin
                    resp_next  = OP_OUT_DONE;
                    state_next = S_RESP;
                end
                else
                    state_next = S_G_RD;
            end
            S_G_RD:
            begin
                op         = OP_GAP_RD;
                state_next = S_G_OUT;
            end
            S_G_OUT:
            begin
                if (st.out_free)
                begin
                    op         = OP_OUT_GAP;
                    state_next = st.gap_last ? S_IDLE : S_G_RD;
                end
            end
            S_O_RD:
            begin
                if (!st.stop && st.more)
                begin
                    op         = OP_READ;
                    state_next = S_O_SCAN;
                end
                else
                    state_next = S_RESP;
            end
            S_O_SCAN:
            begin
                op         = OP_OVL;
                state_next = S_O_RD;
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    op         = resp_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= OP_OUT_DONE;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

endmodule

/* rtl/irgf_datapath.sv */
// ----------------------------------------------------------------------------
// irgf_datapath
// Request registers, interval memory, gap buffer, counters and output stage.
// ----------------------------------------------------------------------------
module irgf_datapath #(
    parameter int NUM_SLOTS     = 16,
    parameter int MAX_INTERVALS = 16,
    parameter int COORD_BITS    = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  irgf_pkg::dp_op_t     op,
    output irgf_pkg::dp_status_t st,
    input  logic [1:0]           in_type,
    input  logic [135:0]         in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_kind,
    output logic [103:0]         out_data,
    output logic                 out_last
);
    import irgf_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int IW    = $clog2(MAX_INTERVALS);
    localparam int GW    = $clog2(MAX_INTERVALS + 2);
    localparam int GIW   = $clog2(MAX_INTERVALS + 1);
    localparam int DEPTH = NUM_SLOTS * MAX_INTERVALS;
    localparam int AW    = $clog2(DEPTH);

    logic [CW-1:0] lo_mem [DEPTH];
    logic [CW-1:0] hi_mem [DEPTH];
    logic [CW-1:0] gs_mem [MAX_INTERVALS + 1];
    logic [CW-1:0] ge_mem [MAX_INTERVALS + 1];
    logic [CNT_W-1:0] count_reg [NUM_SLOTS];

    logic [1:0]       type_reg;
    logic [3:0]       slot_reg;
    logic [CW-1:0]    s_reg, e_reg, rs_reg, re_reg;
    logic             want_reg;
    logic [CNT_W-1:0] n_reg, idx_reg, first_reg, lastm_reg, ins_reg;
    logic             first_found_reg, stop_reg, cov_reg;
    logic [CW:0]      gs_reg;
    logic [CW-1:0]    nlo_reg, nhi_reg;
    logic [GW-1:0]    ngaps_reg, gidx_reg;
    logic [CW:0]      ov_reg;
    logic [CW-1:0]    rd_lo_reg, rd_hi_reg, gap_s_reg, gap_e_reg;

    logic             ov_valid_reg;
    logic [1:0]       o_kind_reg, o_err_reg;
    logic [CW-1:0]    o_gs_reg, o_ge_reg;
    logic [CW:0]      o_cnt_reg;
    logic             o_last_reg;

    // request fields as coordinates
    logic [3:0]    in_slot;
    logic [CW-1:0] in_s, in_e, in_rs, in_re;
    logic [8:0]    in_slot_x;
    logic          in_oob;
    logic [SW-1:0] in_slot_idx, slot_idx;

    assign in_slot     = in_data[3:0];
    assign in_s        = CW'(in_data[35:4]);
    assign in_e        = CW'(in_data[67:36]);
    assign in_rs       = CW'(in_data[99:68]);
    assign in_re       = CW'(in_data[131:100]);
    assign in_slot_x   = {5'd0, in_slot};
    assign in_oob      = (in_slot_x >= 9'(NUM_SLOTS));
    assign in_slot_idx = SW'(in_slot);
    assign slot_idx    = SW'(slot_reg);

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] sl,
                                              input logic [IW-1:0] ix);
        addr_of = AW'(int'(sl) * MAX_INTERVALS + int'(ix));
    endfunction

    // one scan / overlap step on the entry just read
    logic [CW-1:0]    ps, pe, gap_end_scan, ms, me;
    logic [CW:0]      pe1, re1, gs_after, ov_add, full_ov;
    logic             ent_cov, touch, gap_hit, tail_hit;
    logic [CNT_W-1:0] drop, pos, src_idx, new_idx;
    logic [CNT_W:0]   merge_end;
    logic [8:0]       slot_x;

    assign ps           = rd_lo_reg;
    assign pe           = rd_hi_reg;
    assign pe1          = {1'b0, pe} + 1'b1;
    assign re1          = {1'b0, re_reg} + 1'b1;
    assign ent_cov      = (ps <= s_reg) && (pe >= e_reg);
    assign touch        = (pe1 >= {1'b0, rs_reg}) && ({1'b0, ps} <= re1);
    assign gap_hit      = ({1'b0, ps} > gs_reg) && (ngaps_reg <= GW'(MAX_INTERVALS));
    assign gap_end_scan = (re_reg < ps) ? re_reg : (ps - 1'b1);
    assign gs_after     = (rs_reg > pe) ? {1'b0, rs_reg} : pe1;
    assign tail_hit     = (gs_reg <= {1'b0, re_reg}) && (ngaps_reg <= GW'(MAX_INTERVALS));
    assign ms           = (s_reg < ps) ? ps : s_reg;
    assign me           = (e_reg < pe) ? e_reg : pe;
    assign ov_add       = (me >= ms) ? ({1'b0, me - ms} + 1'b1) : '0;
    assign full_ov      = {1'b0, e_reg - s_reg} + 1'b1;

    assign drop      = lastm_reg - first_reg;
    assign pos       = stop_reg ? ins_reg : n_reg;
    assign src_idx   = first_found_reg ? (idx_reg + drop) : (idx_reg - 1'b1);
    assign new_idx   = first_found_reg ? first_reg : pos;
    assign merge_end = {1'b0, idx_reg} + {1'b0, drop};
    assign slot_x    = {5'd0, slot_reg};

    assign st.req_type    = type_reg;
    assign st.bad         = (slot_x >= 9'(NUM_SLOTS)) || (s_reg > e_reg) ||
                            (rs_reg > re_reg) || (rs_reg > s_reg) || (re_reg < e_reg);
    assign st.ovl_empty   = (slot_x >= 9'(NUM_SLOTS)) || (s_reg > e_reg);
    assign st.want        = want_reg;
    assign st.cov         = cov_reg;
    assign st.stop        = stop_reg;
    assign st.more        = (idx_reg < n_reg);
    assign st.first_found = first_found_reg;
    assign st.full        = (n_reg >= CNT_W'(MAX_INTERVALS));
    assign st.merge_more  = (merge_end < {1'b0, n_reg});
    assign st.ins_more    = (idx_reg > pos);
    assign st.gaps_zero   = (ngaps_reg == '0);
    assign st.gap_last    = ((gidx_reg + 1'b1) == ngaps_reg);
    assign st.out_free    = !ov_valid_reg || out_ready;

    // interval memory ports
    logic          mw_en, mr_en;
    logic [AW-1:0] mw_addr, mr_addr;
    logic [CW-1:0] mw_lo, mw_hi;

    always_comb
    begin
        mw_en   = 1'b0;
        mw_addr = addr_of(slot_idx, new_idx[IW-1:0]);
        mw_lo   = nlo_reg;
        mw_hi   = nhi_reg;
        mr_en   = 1'b0;
        mr_addr = addr_of(slot_idx, idx_reg[IW-1:0]);
        case (op)
            OP_READ: mr_en = 1'b1;
            OP_SHIFT_RD:
            begin
                mr_en   = 1'b1;
                mr_addr = addr_of(slot_idx, src_idx[IW-1:0]);
            end
            OP_SHIFT_WR:
            begin
                mw_en   = 1'b1;
                mw_addr = addr_of(slot_idx, idx_reg[IW-1:0]);
                mw_lo   = rd_lo_reg;
                mw_hi   = rd_hi_reg;
            end
            OP_WR_NEW: mw_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            lo_mem[mw_addr] <= mw_lo;
            hi_mem[mw_addr] <= mw_hi;
        end
        if (mr_en)
        begin
            rd_lo_reg <= lo_mem[mr_addr];
            rd_hi_reg <= hi_mem[mr_addr];
        end
    end

    // gap buffer
    logic           gw_en;
    logic [CW-1:0]  gw_s, gw_e;

    always_comb
    begin
        gw_en = 1'b0;
        gw_s  = gs_reg[CW-1:0];
        gw_e  = re_reg;
        if (op == OP_SCAN && !ent_cov && gap_hit)
        begin
            gw_en = 1'b1;
            gw_e  = gap_end_scan;
        end
        else if (op == OP_TAIL && tail_hit)
            gw_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (gw_en)
        begin
            gs_mem[ngaps_reg[GIW-1:0]] <= gw_s;
            ge_mem[ngaps_reg[GIW-1:0]] <= gw_e;
        end
        if (op == OP_GAP_RD)
        begin
            gap_s_reg <= gs_mem[gidx_reg[GIW-1:0]];
            gap_e_reg <= ge_mem[gidx_reg[GIW-1:0]];
        end
    end

    // per-slot fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                count_reg[i] <= '0;
        end
        else if (op == OP_FLUSH)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                count_reg[i] <= '0;
        end
        else if (op == OP_WR_NEW)
            count_reg[slot_idx] <= first_found_reg ? (n_reg - drop) : (n_reg + 1'b1);
    end

    // request state and scan bookkeeping
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                type_reg        <= in_type;
                slot_reg        <= in_slot;
                s_reg           <= in_s;
                e_reg           <= in_e;
                rs_reg          <= in_rs;
                re_reg          <= in_re;
                want_reg        <= in_data[132];
                n_reg           <= in_oob ? '0 : count_reg[in_slot_idx];
                idx_reg         <= '0;
                first_reg       <= '0;
                lastm_reg       <= '0;
                ins_reg         <= '0;
                first_found_reg <= 1'b0;
                stop_reg        <= 1'b0;
                cov_reg         <= 1'b0;
                gs_reg          <= {1'b0, in_rs};
                nlo_reg         <= in_rs;
                nhi_reg         <= in_re;
                ngaps_reg       <= '0;
                gidx_reg        <= '0;
                ov_reg          <= '0;
            end
            OP_SCAN:
            begin
                if (ent_cov)
                begin
                    cov_reg  <= 1'b1;
                    stop_reg <= 1'b1;
                end
                else
                begin
                    if (touch)
                    begin
                        if (!first_found_reg)
                        begin
                            first_found_reg <= 1'b1;
                            first_reg       <= idx_reg;
                            nlo_reg         <= (ps < rs_reg) ? ps : rs_reg;
                        end
                        lastm_reg <= idx_reg;
                        nhi_reg   <= (pe > re_reg) ? pe : re_reg;
                    end
                    if (gap_hit)
                        ngaps_reg <= ngaps_reg + 1'b1;
                    gs_reg <= gs_after;
                    if (pe >= re_reg)
                    begin
                        ins_reg  <= idx_reg;
                        stop_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            OP_TAIL:
            begin
                if (tail_hit)
                    ngaps_reg <= ngaps_reg + 1'b1;
            end
            OP_OVL:
            begin
                if (ps > e_reg)
                    stop_reg <= 1'b1;
                else if (ent_cov)
                begin
                    ov_reg   <= full_ov;
                    stop_reg <= 1'b1;
                end
                else
                    ov_reg <= ov_reg + ov_add;
                idx_reg <= idx_reg + 1'b1;
            end
            OP_MERGE_SETUP: idx_reg <= first_reg + 1'b1;
            OP_INS_SETUP:   idx_reg <= n_reg;
            OP_SHIFT_WR:    idx_reg <= first_found_reg ? (idx_reg + 1'b1) : (idx_reg - 1'b1);
            OP_OUT_GAP:     gidx_reg <= gidx_reg + 1'b1;
            default: ;
        endcase
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_valid_reg <= 1'b0;
        else if (op == OP_OUT_GAP || op == OP_OUT_DONE || op == OP_OUT_ERR_ARG ||
                 op == OP_OUT_ERR_FULL || op == OP_OUT_OVL)
            ov_valid_reg <= 1'b1;
        else if (out_ready)
            ov_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_OUT_GAP || op == OP_OUT_DONE || op == OP_OUT_ERR_ARG ||
            op == OP_OUT_ERR_FULL || op == OP_OUT_OVL)
        begin
            o_gs_reg   <= '0;
            o_ge_reg   <= '0;
            o_cnt_reg  <= '0;
            o_err_reg  <= ERR_NONE;
            o_last_reg <= 1'b1;
            o_kind_reg <= KIND_DONE;
            case (op)
                OP_OUT_GAP:
                begin
                    o_kind_reg <= KIND_GAP;
                    o_gs_reg   <= gap_s_reg;
                    o_ge_reg   <= gap_e_reg;
                    o_last_reg <= st.gap_last;
                end
                OP_OUT_ERR_ARG:
                begin
                    o_kind_reg <= KIND_ERR;
                    o_err_reg  <= ERR_ARG;
                end
                OP_OUT_ERR_FULL:
                begin
                    o_kind_reg <= KIND_ERR;
                    o_err_reg  <= ERR_FULL;
                end
                OP_OUT_OVL:
                begin
                    o_kind_reg <= KIND_OVL;
                    o_cnt_reg  <= ov_reg;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = ov_valid_reg;
    assign out_kind  = o_kind_reg;
    assign out_last  = o_last_reg;
    assign out_data  = {5'd0, o_err_reg, 33'(o_cnt_reg), 32'(o_ge_reg), 32'(o_gs_reg)};

endmodule

/* rtl/interval_registry_gap_finder_top.sv */
// ----------------------------------------------------------------------------
// interval_registry_gap_finder_top
// Per-slot sorted interval registry with gap report, merge and overlap count.
// ----------------------------------------------------------------------------
// Requests enter on the s_* stream (tuser = request type), results leave on
// the m_* stream (tuser = result kind, tlast on the final result of a request).
// One request is processed at a time; s_tready is high only while idle.
// A check-and-register request walks the slot's list (a memory read, then an
// evaluate step, per stored entry visited), then shifts entries for the merge
// or insert (a read, then a write, per moved entry), then emits gaps, each
// read from the gap buffer and then sent. Entries visited plus entries moved
// are at most MAX_INTERVALS + 1. An overlap query walks the list the same
// way. The walk and the shift share the single read port of the interval
// memory.
// Reset clears all slot fill counts (all lists empty); the interval memory
// itself is not cleared. Results wait in an output register while m_tready
// is low; the sequencer simply holds until the register frees up.
// ----------------------------------------------------------------------------
module interval_registry_gap_finder_top #(
    parameter int NUM_SLOTS     = 16,
    parameter int MAX_INTERVALS = 16,
    parameter int COORD_BITS    = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot_id[3:0], check_start[35:4], check_end[67:36], reg_start[99:68],
    // reg_end[131:100], want_gaps[132], zero fill
    input  logic [135:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // gap_start[31:0], gap_end[63:32], overlap_count[96:64], error_code[98:97],
    // zero fill
    output logic [103:0] m_tdata,
    // result_kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    import irgf_pkg::*;

    dp_op_t     op;
    dp_status_t st;

    irgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .op       (op)
    );

    irgf_datapath #(
        .NUM_SLOTS     (NUM_SLOTS),
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_BITS    (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .st        (st),
        .in_type   (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

/* test/interval_registry_gap_finder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_registry_gap_finder_top_tb
// Drives check, overlap, flush and unused-type requests into the registry and checks
// every result against a behavioral copy of the per-slot interval lists.
// ----------------------------------------------------------------------------
module interval_registry_gap_finder_top_tb;
    import irgf_pkg::*;

    localparam int SLOTS   = 16;
    localparam int MAXIV   = 16;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] gs;
        logic [31:0] ge;
        logic [32:0] cnt;
        logic [1:0]  err;
        logic        lst;
    } result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    interval_registry_gap_finder_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the registry
    logic [31:0] lo_q [SLOTS][MAXIV];
    logic [31:0] hi_q [SLOTS][MAXIV];
    int          cnt_q [SLOTS];

    result_t results_due[$];
    int      errors = 0;
    int      n_sent = 0;
    int      n_rcvd = 0;
    int      idle_cycles = 0;
    bit      idle_on = 1'b1;
    int      hold_cycles = 0;

    function automatic result_t mk(logic [1:0] k, logic [31:0] a, logic [31:0] b,
                                   logic [32:0] c, logic [1:0] e, logic l);
        result_t r;
        r.kind = k; r.gs = a; r.ge = b; r.cnt = c; r.err = e; r.lst = l;
        return r;
    endfunction

    task automatic predict_registry(logic [1:0] rt, logic [3:0] slot, logic [31:0] s,
                                    logic [31:0] e, logic [31:0] rs, logic [31:0] re,
                                    logic want);
        logic [63:0] gsl [MAXIV+1];
        logic [63:0] gel [MAXIV+1];
        logic [63:0] gap_st, ps, pe, nlo, nhi, ov, ms, me;
        int ng, n, first, lastm, ins, drop, pos;
        ng = 0; first = -1; lastm = -1; ins = -1; ov = 0;
        if (rt == REQ_OVL) begin
            if (s <= e)
                for (int i = 0; i < cnt_q[slot]; i++) begin
                    ps = lo_q[slot][i]; pe = hi_q[slot][i];
                    if (ps > e) break;
                    if (ps <= s && pe >= e) begin
                        ov = 64'(e) - s + 1;
                        break;
                    end
                    ms = (s < ps) ? ps : 64'(s);
                    me = (e < pe) ? 64'(e) : pe;
                    if (me >= ms) ov += me - ms + 1;
                end
            results_due.push_back(mk(KIND_OVL, 0, 0, ov[32:0], ERR_NONE, 1'b1));
            return;
        end
        if (rt != REQ_CHECK) begin
            if (rt == REQ_FLUSH)
                for (int i = 0; i < SLOTS; i++) cnt_q[i] = 0;
            results_due.push_back(mk(KIND_DONE, 0, 0, 0, ERR_NONE, 1'b1));
            return;
        end
        if (s > e || rs > re || rs > s || re < e) begin
            results_due.push_back(mk(KIND_ERR, 0, 0, 0, ERR_ARG, 1'b1));
            return;
        end
        n = cnt_q[slot];
        if (n == 0) begin
            lo_q[slot][0] = rs; hi_q[slot][0] = re; cnt_q[slot] = 1;
            if (want) results_due.push_back(mk(KIND_GAP, rs, re, 0, ERR_NONE, 1'b1));
            else results_due.push_back(mk(KIND_DONE, 0, 0, 0, ERR_NONE, 1'b1));
            return;
        end
        gap_st = rs;
        for (int i = 0; i < n; i++) begin
            ps = lo_q[slot][i]; pe = hi_q[slot][i];
            if (ps <= s && pe >= e) begin
                results_due.push_back(mk(KIND_DONE, 0, 0, 0, ERR_NONE, 1'b1));
                return;
            end
            if (pe + 1 >= rs && ps <= 64'(re) + 1) begin
                if (first < 0) first = i;
                lastm = i;
            end
            if (ps > gap_st && ng <= MAXIV) begin
                gsl[ng] = gap_st;
                gel[ng] = (re < ps) ? 64'(re) : ps - 1;
                ng++;
            end
            gap_st = (rs > pe) ? 64'(rs) : pe + 1;
            if (pe >= re) begin
                ins = i;
                break;
            end
        end
        if (gap_st <= re && ng <= MAXIV) begin
            gsl[ng] = gap_st; gel[ng] = re; ng++;
        end
        if (first >= 0) begin
            nlo = lo_q[slot][first]; nhi = hi_q[slot][lastm];
            drop = lastm - first;
            if (rs < nlo) nlo = rs;
            if (re > nhi) nhi = re;
            for (int i = first + 1; i + drop < n; i++) begin
                lo_q[slot][i] = lo_q[slot][i+drop];
                hi_q[slot][i] = hi_q[slot][i+drop];
            end
            lo_q[slot][first] = nlo[31:0]; hi_q[slot][first] = nhi[31:0];
            cnt_q[slot] = n - drop;
        end else begin
            pos = (ins >= 0) ? ins : n;
            if (n >= MAXIV) begin
                results_due.push_back(mk(KIND_ERR, 0, 0, 0, ERR_FULL, 1'b1));
                return;
            end
            for (int i = n; i > pos; i--) begin
                lo_q[slot][i] = lo_q[slot][i-1];
                hi_q[slot][i] = hi_q[slot][i-1];
            end
            lo_q[slot][pos] = rs; hi_q[slot][pos] = re;
            cnt_q[slot] = n + 1;
        end
        if (!want || ng == 0)
            results_due.push_back(mk(KIND_DONE, 0, 0, 0, ERR_NONE, 1'b1));
        else
            for (int i = 0; i < ng; i++)
                results_due.push_back(mk(KIND_GAP, gsl[i][31:0], gel[i][31:0], 0, ERR_NONE,
                                         i == ng - 1));
    endtask

    task automatic send_request(logic [1:0] rt, logic [3:0] slot, logic [31:0] s,
                                logic [31:0] e, logic [31:0] rs, logic [31:0] re,
                                logic want);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        s_tdata <= {3'b0, want, re, rs, e, s, slot};
        s_tuser <= rt;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_registry(rt, slot, s, e, rs, re, want);
        n_sent++;
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_check(logic [3:0] slot, logic [31:0] rs, logic [31:0] re, logic want);
        send_request(REQ_CHECK, slot, rs, re, rs, re, want);
    endtask

    // receiver: random bursts of backpressure, plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (idle_on)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t got, want_r;
        if (m_tvalid && m_tready) begin
            got = mk(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[96:64],
                     m_tdata[98:97], m_tlast);
            n_rcvd++;
            if (results_due.size() == 0) begin
                $error("unexpected result transaction kind=%0d", m_tuser);
                errors++;
            end else begin
                want_r = results_due.pop_front();
                if (got.kind != want_r.kind) begin
                    $error("result_kind exp %0d got %0d", want_r.kind, got.kind); errors++;
                end
                if (got.gs != want_r.gs) begin
                    $error("gap_start exp %0h got %0h", want_r.gs, got.gs); errors++;
                end
                if (got.ge != want_r.ge) begin
                    $error("gap_end exp %0h got %0h", want_r.ge, got.ge); errors++;
                end
                if (got.cnt != want_r.cnt) begin
                    $error("overlap_count exp %0h got %0h", want_r.cnt, got.cnt); errors++;
                end
                if (got.err != want_r.err) begin
                    $error("error_code exp %0d got %0d", want_r.err, got.err); errors++;
                end
                if (got.lst != want_r.lst) begin
                    $error("last exp %0d got %0d", want_r.lst, got.lst); errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("interval_registry_gap_finder_top verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            1: return $urandom();
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    task automatic test_directed();
        send_request(REQ_FLUSH, 0, 0, 0, 0, 0, 0);
        send_check(0, 100, 200, 1);              // first use of a slot
        send_check(0, 120, 150, 1);              // already covered
        send_check(0, 300, 400, 1);
        send_request(REQ_CHECK, 0, 150, 350, 50, 450, 1); // gaps across two
        send_check(0, 500, 600, 0);              // silent
        send_check(0, 601, 700, 1);              // adjacent merge
        send_request(REQ_CHECK, 1, 10, 5, 5, 10, 1);     // start above end
        send_request(REQ_CHECK, 1, 5, 10, 6, 10, 1);     // reg_start above check
        send_request(REQ_CHECK, 1, 5, 10, 5, 9, 1);      // reg_end below check
        send_request(REQ_CHECK, 1, 5, 10, 9, 2, 1);
        send_check(15, 0, 32'hFFFF_FFFF, 1);
        send_check(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_request(REQ_OVL, 15, 0, 32'hFFFF_FFFF, 0, 0, 0); // full 2^32 count
        send_request(REQ_OVL, 0, 0, 1000, 0, 0, 0);
        send_request(REQ_OVL, 0, 10, 5, 0, 0, 0);        // empty range
        send_request(REQ_OVL, 7, 0, 100, 0, 0, 0);       // empty slot
        send_request(2'd3, 0, 0, 0, 0, 0, 1);            // unused type
        // fill slot 2 to capacity, then overflow it
        for (int i = 0; i < MAXIV + 1; i++)
            send_check(2, i * 10, i * 10 + 3, 1);
        send_request(REQ_FLUSH, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        logic [31:0] a, b, c, d;
        logic [1:0] rt;
        for (int k = 0; k < count; k++) begin
            a = rnd_coord(); b = rnd_coord();
            if (a > b) begin c = a; a = b; b = c; end
            c = (a > 20 && $urandom_range(0, 1)) ? a - $urandom_range(0, 20) : a;
            d = (b < 32'hFFFF_FFEB && $urandom_range(0, 1)) ? b + $urandom_range(0, 20) : b;
            case ($urandom_range(0, 19))
                0:       rt = REQ_FLUSH;
                1:       rt = 2'd3;
                2, 3, 4: rt = REQ_OVL;
                default: rt = REQ_CHECK;
            endcase
            if ($urandom_range(0, 9) == 0) begin
                // noise: arbitrary bounds
                a = $urandom(); b = $urandom(); c = $urandom(); d = $urandom();
            end
            send_request(rt, 4'($urandom_range(0, 15)), a, b, c, d, 1'($urandom_range(0, 7) != 0));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_check(3, i * 7, i * 7 + 2, 1);
        wait (hold_cycles == 0);
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++) cnt_q[i] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(380);
        idle_on = 1'b0;
        test_random(60);
        while (results_due.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d requests, checked %0d results across all request kinds,", n_sent,
                 n_rcvd);
        $display("including list overflow, flush, bad bounds and long output stalls.");
        if (errors == 0)
            $display("interval_registry_gap_finder_top verification clean");
        else
            $display("interval_registry_gap_finder_top verification failed");
        $finish;
    end

endmodule
